>>> rtl/core/wth_pkg.sv
// wth_pkg: constants, result type and byte classification helpers for the
// word tokenizer / fnv-1a hasher. no dependencies.
`default_nettype none

package wth_pkg;

    localparam int HASH_BITS = 16;
    localparam int MAX_WORD  = 256;

    localparam int HASH_W = 32;
    localparam int BKT_W  = 16;
    localparam int LINE_W = 24;
    localparam int COL_W  = 16;
    localparam int LEN_W  = 8;

    localparam logic [HASH_W-1:0] FNV_BASIS = 32'd2166136261;
    localparam logic [HASH_W-1:0] FNV_PRIME = 32'd16777619;
    localparam logic [HASH_W-1:0] BUCKET_MASK =
        HASH_W'((64'd1 << HASH_BITS) - 64'd1);

    localparam logic [LEN_W-1:0]  KEEP_MAX = LEN_W'(MAX_WORD - 1);
    localparam logic [LINE_W-1:0] LINE_MAX = '1;
    localparam logic [COL_W-1:0]  COL_MAX  = '1;
    localparam logic [LINE_W-1:0] LINE_FIRST = LINE_W'(1);

    localparam logic [7:0] CH_APOS    = 8'h27;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_UP_A    = 8'h41;
    localparam logic [7:0] CH_UP_Z    = 8'h5A;
    localparam logic [7:0] CH_LO_A    = 8'h61;
    localparam logic [7:0] CH_LO_Z    = 8'h7A;
    localparam logic [7:0] CASE_DELTA = 8'h20;

    typedef struct packed {
        logic [HASH_W-1:0] word_hash;
        logic [BKT_W-1:0]  bucket_index;
        logic [LINE_W-1:0] word_line;
        logic [COL_W-1:0]  first_col;
        logic [LEN_W-1:0]  word_length;
    } result_t;

    function automatic logic is_word_byte(input logic [7:0] c);
        return c inside {[CH_UP_A:CH_UP_Z], [CH_LO_A:CH_LO_Z], CH_APOS};
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c inside {[CH_UP_A:CH_UP_Z]})
        begin
            r = c + CASE_DELTA;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/wth_if.sv
// wth_in_if / wth_out_if: valid-ready channels for text bytes and word results.
// field widths are written out to match wth_pkg; no dependencies.
`default_nettype none

interface wth_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_input;

    modport source (output valid, output in_byte, output end_of_input, input ready);
    modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface wth_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] word_hash;
    logic [15:0] bucket_index;
    logic [23:0] word_line;
    logic [15:0] first_col;
    logic [7:0]  word_length;

    modport source (output valid, output word_hash, output bucket_index,
                    output word_line, output first_col, output word_length,
                    input ready);
    modport sink   (input valid, input word_hash, input bucket_index,
                    input word_line, input first_col, input word_length,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/core/wth_scan.sv
// wth_scan: tokenizer state (hash, length, line, column) and per-byte update.
// depends on wth_pkg.
`default_nettype none

module wth_scan (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             fire,
    input  wire logic [7:0]       in_byte,
    input  wire logic             end_of_input,
    output wth_pkg::result_t      res,
    output logic                  res_valid
);
    import wth_pkg::*;

    logic [HASH_W-1:0] hash_reg,  hash_next;
    logic [LEN_W-1:0]  len_reg,   len_next;
    logic [LINE_W-1:0] line_reg,  line_next;
    logic [COL_W-1:0]  col_reg,   col_next;
    logic [COL_W-1:0]  start_reg, start_next;

    logic [COL_W-1:0]  col_inc;
    logic [HASH_W-1:0] hash_mix;
    logic              word_byte;
    logic              pending;

    assign pending   = (len_reg != '0);
    assign word_byte = is_word_byte(in_byte);
    assign col_inc   = (col_reg == COL_MAX) ? col_reg : col_reg + COL_W'(1);
    assign hash_mix  = hash_reg ^ {{(HASH_W-8){1'b0}}, to_lower(in_byte)};

    assign res.word_hash    = hash_reg;
    assign res.bucket_index = BKT_W'(hash_reg & BUCKET_MASK);
    assign res.word_line    = line_reg;
    assign res.first_col    = start_reg;
    assign res.word_length  = len_reg;

    always_comb
    begin
        hash_next  = hash_reg;
        len_next   = len_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        start_next = start_reg;
        res_valid  = 1'b0;
        if (fire)
        begin
            if (end_of_input)
            begin
                res_valid = pending;
                hash_next = FNV_BASIS;
                len_next  = '0;
                line_next = LINE_FIRST;
                col_next  = '0;
            end
            else if (word_byte)
            begin
                col_next = col_inc;
                if (!pending)
                begin
                    start_next = col_inc;
                end
                if (len_reg < KEEP_MAX)
                begin
                    hash_next = hash_mix * FNV_PRIME;
                    len_next  = len_reg + LEN_W'(1);
                end
            end
            else
            begin
                res_valid = pending;
                hash_next = FNV_BASIS;
                len_next  = '0;
                col_next  = col_inc;
                if (in_byte == CH_NEWLINE)
                begin
                    col_next = '0;
                    if (line_reg != LINE_MAX)
                    begin
                        line_next = line_reg + LINE_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg  <= FNV_BASIS;
            len_reg   <= '0;
            line_reg  <= LINE_FIRST;
            col_reg   <= '0;
            start_reg <= '0;
        end
        else
        begin
            hash_reg  <= hash_next;
            len_reg   <= len_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            start_reg <= start_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/wth_out_reg.sv
// wth_out_reg: result register that holds a word transaction until taken.
// depends on wth_pkg.
`default_nettype none

module wth_out_reg (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire wth_pkg::result_t res,
    input  wire logic             out_ready,
    output logic                  out_valid,
    output wth_pkg::result_t      out_res,
    output logic                  space
);
    import wth_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign space      = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);
    assign out_valid  = valid_reg;
    assign out_res    = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/word_tokenizer_fnv_hasher_core.sv
// word_tokenizer_fnv_hasher_core: top level of the word tokenizer / fnv-1a hasher.
// depends on wth_pkg, wth_if, wth_scan and wth_out_reg.
`default_nettype none

// Takes one text byte per cycle, except while a finished word waits for the
// sink, and emits one transaction per word: its 32-bit FNV-1a hash, bucket
// index, line, start column and kept length. A word is reported on the cycle
// after the byte (or end-of-input flag) that ends it; letters are lowercased
// and words keep at most MAX_WORD-1 characters; the byte rate is set by the hash
// loop (one xor and one constant multiply per byte). The result register holds
// a word until taken, stalling input meanwhile. No start-up pass after reset.
module word_tokenizer_fnv_hasher_core (
    input  wire logic  clk,
    input  wire logic  rst_n,
    wth_in_if.sink     in_ch,
    wth_out_if.source  out_ch
);
    import wth_pkg::*;

    logic    fire;
    logic    res_valid;
    logic    space;
    result_t res;
    result_t out_res;

    assign in_ch.ready = space;
    assign fire        = in_ch.valid && space;

    wth_scan u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (fire),
        .in_byte      (in_ch.in_byte),
        .end_of_input (in_ch.end_of_input),
        .res          (res),
        .res_valid    (res_valid)
    );

    wth_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_valid),
        .res       (res),
        .out_ready (out_ch.ready),
        .out_valid (out_ch.valid),
        .out_res   (out_res),
        .space     (space)
    );

    assign out_ch.word_hash    = out_res.word_hash;
    assign out_ch.bucket_index = out_res.bucket_index;
    assign out_ch.word_line    = out_res.word_line;
    assign out_ch.first_col    = out_res.first_col;
    assign out_ch.word_length  = out_res.word_length;

`ifndef SYNTHESIS
    a_word_byte_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready && !in_ch.end_of_input
            && is_word_byte(in_ch.in_byte)) |=> !out_ch.valid)
        else $error("word byte produced a result");

    a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_ch.valid) |-> $past(in_ch.valid && in_ch.ready))
        else $error("result without an accepted byte");

    a_result_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.word_length != 8'd0 && out_ch.word_line != 24'd0
            && out_ch.first_col != 16'd0))
        else $error("result with empty length, line or column");
`endif

endmodule

`default_nettype wire
